// ===== src/sha1_pkg.sv =====
// sha1_pkg: shared types and constants of the sha-1 hash engine
// holds the controller state encoding, the round control bundle and the sha-1 constants
// no dependencies
package sha1_pkg;

   localparam int WORD_W    = 32;
   localparam int BLK_AW    = 4;   // 16 words of block buffer
   localparam int CHAIN_AW  = 3;   // 5 words of chaining value
   localparam int ROUND_W   = 7;   // round counter, 0..79
   localparam int COUNT_W   = 61;  // message byte count

   localparam logic [WORD_W-1:0] K_R0 = 32'h5A82_7999;
   localparam logic [WORD_W-1:0] K_R1 = 32'h6ED9_EBA1;
   localparam logic [WORD_W-1:0] K_R2 = 32'h8F1B_BCDC;
   localparam logic [WORD_W-1:0] K_R3 = 32'hCA62_C1D6;

   localparam logic [WORD_W-1:0] PAD_MARK_WORD = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_DREAD,
      ST_DSEND
   } state_type;

   typedef struct packed {
      logic                load;   // shift a chain word into a..e
      logic                step;   // run one round
      logic [ROUND_W-1:0]  round;  // round number of this step
      logic [CHAIN_AW-1:0] sel;    // working variable on rv_word
   } rnd_ctrl_type;

   function automatic logic [WORD_W-1:0] init_word(input logic [CHAIN_AW-1:0] idx);
      logic [WORD_W-1:0] w;
      begin
         unique case (idx)
            3'd0:    w = 32'h6745_2301;
            3'd1:    w = 32'hEFCD_AB89;
            3'd2:    w = 32'h98BA_DCFE;
            3'd3:    w = 32'h1032_5476;
            3'd4:    w = 32'hC3D2_E1F0;
            default: w = '0;
         endcase
         return w;
      end
   endfunction

endpackage

// ===== src/sha1_blk_mem.sv =====
// sha1_blk_mem: 16-word block buffer, one write and one read port
// read data is registered
// depends on sha1_pkg
module sha1_blk_mem (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [sha1_pkg::BLK_AW-1:0]                wr_addr,
   input  logic [sha1_pkg::WORD_W-1:0]                wr_data,
   input  logic                                       rd_en,
   input  logic [sha1_pkg::BLK_AW-1:0]                rd_addr,
   output logic [sha1_pkg::WORD_W-1:0]                rd_data
);

   logic [sha1_pkg::WORD_W-1:0] mem [2**sha1_pkg::BLK_AW];
   logic [sha1_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sha1_round_core.sv =====
// sha1_round_core: working variables a..e and the 16-word message schedule window
// one sha-1 round per step, schedule words 0..15 come from the block buffer
// depends on sha1_pkg
module sha1_round_core (
   input  logic                          clock,
   input  sha1_pkg::rnd_ctrl_type        ctrl,
   input  logic [sha1_pkg::WORD_W-1:0]   chain_word,
   input  logic [sha1_pkg::WORD_W-1:0]   buf_word,
   output logic [sha1_pkg::WORD_W-1:0]   rv_word
);

   logic [sha1_pkg::WORD_W-1:0] rv_ff    [5];
   logic [sha1_pkg::WORD_W-1:0] sched_ff [16];

   logic [sha1_pkg::WORD_W-1:0] wt;
   logic [sha1_pkg::WORD_W-1:0] f_val;
   logic [sha1_pkg::WORD_W-1:0] k_val;
   logic [sha1_pkg::WORD_W-1:0] sum;
   logic [sha1_pkg::WORD_W-1:0] mix;

   // schedule: sched_ff[k] holds w[t-16+k]
   always_comb begin
      mix = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      if (ctrl.round < 7'd16) begin
         wt = buf_word;
      end else begin
         wt = {mix[30:0], mix[31]};
      end
   end

   always_comb begin
      if (ctrl.round < 7'd20) begin
         f_val = (rv_ff[1] & rv_ff[2]) | (~rv_ff[1] & rv_ff[3]);
         k_val = sha1_pkg::K_R0;
      end else if (ctrl.round < 7'd40) begin
         f_val = rv_ff[1] ^ rv_ff[2] ^ rv_ff[3];
         k_val = sha1_pkg::K_R1;
      end else if (ctrl.round < 7'd60) begin
         f_val = (rv_ff[1] & rv_ff[2]) | (rv_ff[1] & rv_ff[3]) | (rv_ff[2] & rv_ff[3]);
         k_val = sha1_pkg::K_R2;
      end else begin
         f_val = rv_ff[1] ^ rv_ff[2] ^ rv_ff[3];
         k_val = sha1_pkg::K_R3;
      end
      sum = {rv_ff[0][26:0], rv_ff[0][31:27]} + f_val + rv_ff[4] + k_val + wt;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         // words arrive h4 first, so h0 ends up in a
         rv_ff[4] <= rv_ff[3];
         rv_ff[3] <= rv_ff[2];
         rv_ff[2] <= rv_ff[1];
         rv_ff[1] <= rv_ff[0];
         rv_ff[0] <= chain_word;
      end else if (ctrl.step) begin
         rv_ff[4] <= rv_ff[3];
         rv_ff[3] <= rv_ff[2];
         rv_ff[2] <= {rv_ff[1][1:0], rv_ff[1][31:2]};
         rv_ff[1] <= rv_ff[0];
         rv_ff[0] <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[15] <= wt;
      end
   end

   always_comb begin
      unique case (ctrl.sel)
         3'd0:    rv_word = rv_ff[0];
         3'd1:    rv_word = rv_ff[1];
         3'd2:    rv_word = rv_ff[2];
         3'd3:    rv_word = rv_ff[3];
         3'd4:    rv_word = rv_ff[4];
         default: rv_word = '0;
      endcase
   end

endmodule

// ===== src/sha1_hash_engine.sv =====
// sha1_hash_engine: sha-1 digest of a word stream; non-last words go into the block buffer,
// the word that fills a block starts a compression (chain load, 80 rounds, chain update) on the
// single shared round unit, during which no word is taken; a last word adds padding
// (at most 18 buffer writes), one or two compressions, then 5 digest words
// reset: synchronous; after reset the engine first writes the initial chain value into the
// chain memory, no word is taken during that sweep
module sha1_hash_engine (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_word [31:0], valid_bytes [34:32], zero [39:35]
   input  logic        req_tlast,   // last word of the message

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word [31:0], word_index [34:32], zero [39:35]
   output logic        rsp_tlast    // fifth digest word
);

   localparam int WW = sha1_pkg::WORD_W;
   localparam int CW = sha1_pkg::COUNT_W;

   // controller registers
   sha1_pkg::state_type               state_ff, state_in;
   logic [sha1_pkg::ROUND_W-1:0]      cnt_ff, cnt_in;       // round, load and word counter
   logic [CW-1:0]                     byte_cnt_ff, byte_cnt_in;
   logic [sha1_pkg::BLK_AW:0]         wptr_ff, wptr_in;     // padding write pointer
   logic                              pad_ff, pad_in;       // message tail in progress
   logic                              mark_ff, mark_in;     // 0x80 marker word still owed
   logic                              len_ok_ff, len_ok_in; // this block carries the length

   // chain memory, 5 words
   logic [WW-1:0]                     chain_mem [5];
   logic [WW-1:0]                     ch_rdata_ff;
   logic                              ch_wr_en, ch_rd_en;
   logic [sha1_pkg::CHAIN_AW-1:0]     ch_wr_addr, ch_rd_addr;
   logic [WW-1:0]                     ch_wr_data;

   // block buffer ports
   logic                              blk_wr_en, blk_rd_en;
   logic [sha1_pkg::BLK_AW-1:0]       blk_wr_addr, blk_rd_addr;
   logic [WW-1:0]                     blk_wr_data, blk_rd_data;

   sha1_pkg::rnd_ctrl_type            rctl;
   logic [WW-1:0]                     rv_word;

   // input word decode
   logic [sha1_pkg::BLK_AW-1:0]       pos;
   logic [2:0]                        nb_sat;
   logic [WW-1:0]                     tail_word;

   assign pos    = byte_cnt_ff[5:2];
   assign nb_sat = (req_tdata[34:32] > 3'd4) ? 3'd4 : req_tdata[34:32];

   // keep the valid leading bytes and, when fewer than four, place the 0x80 marker right after them
   always_comb begin
      unique case (nb_sat)
         3'd0:    tail_word = sha1_pkg::PAD_MARK_WORD;
         3'd1:    tail_word = {req_tdata[31:24], 24'h80_0000};
         3'd2:    tail_word = {req_tdata[31:16], 16'h8000};
         3'd3:    tail_word = {req_tdata[31:8], 8'h80};
         default: tail_word = req_tdata[31:0];
      endcase
   end

   sha1_blk_mem u_blk_mem (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (blk_wr_addr),
      .wr_data (blk_wr_data),
      .rd_en   (blk_rd_en),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   sha1_round_core u_round_core (
      .clock      (clock),
      .ctrl       (rctl),
      .chain_word (ch_rdata_ff),
      .buf_word   (blk_rd_data),
      .rv_word    (rv_word)
   );

   // chain memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ch_wr_en) begin
         chain_mem[ch_wr_addr] <= ch_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ch_rd_en) begin
         ch_rdata_ff <= chain_mem[ch_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha1_pkg::ST_INIT;
         cnt_ff      <= '0;
         byte_cnt_ff <= '0;
         wptr_ff     <= '0;
         pad_ff      <= 1'b0;
         mark_ff     <= 1'b0;
         len_ok_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         byte_cnt_ff <= byte_cnt_in;
         wptr_ff     <= wptr_in;
         pad_ff      <= pad_in;
         mark_ff     <= mark_in;
         len_ok_ff   <= len_ok_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      wptr_in     = wptr_ff;
      pad_in      = pad_ff;
      mark_in     = mark_ff;
      len_ok_in   = len_ok_ff;

      blk_wr_en   = 1'b0;
      blk_wr_addr = wptr_ff[sha1_pkg::BLK_AW-1:0];
      blk_wr_data = '0;
      blk_rd_en   = 1'b0;
      blk_rd_addr = cnt_ff[sha1_pkg::BLK_AW-1:0] + 4'd1;

      ch_wr_en    = 1'b0;
      ch_wr_addr  = cnt_ff[2:0];
      ch_wr_data  = sha1_pkg::init_word(cnt_ff[2:0]);
      ch_rd_en    = 1'b0;
      ch_rd_addr  = cnt_ff[2:0];

      rctl        = '0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;

      unique case (state_ff)
         // sweep the initial chain value into the chain memory
         sha1_pkg::ST_INIT: begin
            ch_wr_en = 1'b1;
            if (cnt_ff == 7'd4) begin
               state_in = sha1_pkg::ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end

         // take message words into the block buffer
         sha1_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            blk_wr_addr = pos;
            if (req_tvalid) begin
               blk_wr_en = 1'b1;
               if (!req_tlast) begin
                  blk_wr_data = req_tdata[31:0];
                  byte_cnt_in = byte_cnt_ff + 61'd4;
                  if (pos == 4'd15) begin
                     state_in = sha1_pkg::ST_LOAD;
                     cnt_in   = '0;
                     pad_in   = 1'b0;
                  end
               end else begin
                  blk_wr_data = tail_word;
                  byte_cnt_in = byte_cnt_ff + {58'd0, nb_sat};
                  wptr_in     = {1'b0, pos} + 5'd1;
                  mark_in     = (nb_sat == 3'd4);
                  len_ok_in   = (pos <= 4'd13);
                  pad_in      = 1'b1;
                  state_in    = sha1_pkg::ST_PAD;
               end
            end
         end

         // fill the rest of the block: marker if owed, zeros, bit length in words 14 and 15
         sha1_pkg::ST_PAD: begin
            if (wptr_ff[sha1_pkg::BLK_AW]) begin
               state_in = sha1_pkg::ST_LOAD;
               cnt_in   = '0;
            end else begin
               blk_wr_en = 1'b1;
               wptr_in   = wptr_ff + 5'd1;
               priority if (mark_ff) begin
                  blk_wr_data = sha1_pkg::PAD_MARK_WORD;
                  mark_in     = 1'b0;
                  len_ok_in   = (wptr_ff <= 5'd13);
               end else if (len_ok_ff && wptr_ff == 5'd14) begin
                  blk_wr_data = byte_cnt_ff[60:29];
               end else if (len_ok_ff && wptr_ff == 5'd15) begin
                  blk_wr_data = {byte_cnt_ff[28:0], 3'b000};
               end else begin
                  blk_wr_data = '0;
               end
            end
         end

         // read h4..h0 into a..e, then prefetch schedule word 0
         sha1_pkg::ST_LOAD: begin
            ch_rd_addr = 3'd4 - cnt_ff[2:0];
            ch_rd_en   = (cnt_ff < 7'd5);
            rctl.load  = (cnt_ff != 7'd0);
            if (cnt_ff == 7'd5) begin
               blk_rd_en   = 1'b1;
               blk_rd_addr = '0;
               state_in    = sha1_pkg::ST_ROUND;
               cnt_in      = '0;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end

         // one round a cycle, buffer word t+1 is read during round t
         sha1_pkg::ST_ROUND: begin
            rctl.step  = 1'b1;
            rctl.round = cnt_ff;
            blk_rd_en  = (cnt_ff < 7'd15);
            if (cnt_ff == 7'd79) begin
               state_in = sha1_pkg::ST_FINAL;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end

         // read h[i] while h[i-1] + var[i-1] is written back
         sha1_pkg::ST_FINAL: begin
            ch_rd_en   = (cnt_ff < 7'd5);
            rctl.sel   = cnt_ff[2:0] - 3'd1;
            ch_wr_addr = cnt_ff[2:0] - 3'd1;
            ch_wr_data = ch_rdata_ff + rv_word;
            ch_wr_en   = (cnt_ff != 7'd0);
            if (cnt_ff == 7'd5) begin
               cnt_in = '0;
               priority if (!pad_ff) begin
                  state_in = sha1_pkg::ST_IDLE;
               end else if (len_ok_ff && !mark_ff) begin
                  state_in = sha1_pkg::ST_DREAD;
               end else begin
                  // marker, if still owed, and length go in the next block
                  state_in  = sha1_pkg::ST_PAD;
                  wptr_in   = '0;
                  len_ok_in = 1'b1;
               end
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end

         sha1_pkg::ST_DREAD: begin
            ch_rd_en = 1'b1;
            state_in = sha1_pkg::ST_DSEND;
         end

         // present digest word, restore the initial chain word once taken
         sha1_pkg::ST_DSEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               ch_wr_en = 1'b1;
               if (cnt_ff == 7'd4) begin
                  state_in    = sha1_pkg::ST_IDLE;
                  cnt_in      = '0;
                  byte_cnt_in = '0;
                  pad_in      = 1'b0;
               end else begin
                  state_in = sha1_pkg::ST_DREAD;
                  cnt_in   = cnt_ff + 7'd1;
               end
            end
         end

         default: begin
            state_in = sha1_pkg::ST_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   assign rsp_tdata = {5'b0_0000, cnt_ff[2:0], ch_rdata_ff};
   assign rsp_tlast = (cnt_ff[2:0] == 3'd4);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for sha1_hash_engine, a sha-1 digest engine on a word stream
// holds its own sha-1 predictor, a directed stimulus table and random messages
// depends only on the sha1_hash_engine rtl

module tb;

   // digest word as the result side should deliver it
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        fin;
   } digest_word_type;

   // one row of the directed table; digest is used only where typed is set
   typedef struct packed {
      logic [31:0]      data;
      logic [2:0]       nb;
      logic             fin;
      logic             typed;
      logic [0:4][31:0] digest;
   } stim_row_type;

   localparam int DIR_ROWS = 23;
   localparam int RAND_PER_PHASE = 100;

   localparam logic [0:4][31:0] H_START = {
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };
   localparam logic [0:3][31:0] ROUND_K = {
      32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
   };

   // well-known digests of short messages
   localparam logic [0:4][31:0] DIGEST_EMPTY = {
      32'hDA39_A3EE, 32'h5E6B_4B0D, 32'h3255_BFEF, 32'h9560_1890, 32'hAFD8_0709
   };
   localparam logic [0:4][31:0] DIGEST_ABC = {
      32'hA999_3E36, 32'h4706_816A, 32'hBA3E_2571, 32'h7850_C26C, 32'h9CD0_D89D
   };
   localparam logic [0:4][31:0] DIGEST_A = {
      32'h86F7_E437, 32'hFAA5_A7FC, 32'hE15D_1DDC, 32'hB9EA_EAEA, 32'h3776_67B8
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // data_word [31:0], valid_bytes [34:32], zero [39:35]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // digest_word [31:0], word_index [34:32], zero [39:35]
   logic        rsp_tlast;

   sha1_hash_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: chaining value, block buffer and running byte count
   logic [31:0] hash_h [5];
   logic [31:0] blk_w [16];
   logic [60:0] msg_bytes;

   digest_word_type digest_q [$];
   int mismatch_count = 0;
   int words_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int rsp_hold_cycles = 0;

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // one 80-round compression of blk_w into hash_h
   function automatic void sha1_compress();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, k, wt, t;
      int r;
      sched = blk_w;
      a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
      for (r = 0; r < 80; r++) begin
         if (r >= 16) begin
            wt = rol(sched[4'(r + 13)] ^ sched[4'(r + 8)] ^
                     sched[4'(r + 2)] ^ sched[4'(r)], 1);
            sched[4'(r)] = wt;
         end else begin
            wt = sched[4'(r)];
         end
         if (r < 20)
            f = (b & c) | (~b & d);
         else if (r < 40 || r >= 60)
            f = b ^ c ^ d;
         else
            f = (b & c) | (b & d) | (c & d);
         k = ROUND_K[2'(r / 20)];
         t = rol(a, 5) + f + e + k + wt;
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
   endfunction

   function automatic void hash_restart();
      for (int i = 0; i < 5; i++)
         hash_h[3'(i)] = H_START[3'(i)];
      msg_bytes = '0;
   endfunction

   // take one accepted word; on the last word pad, finish and hand back the digest
   function automatic void absorb_word(input logic [31:0] data, input logic [2:0] nb_in,
                                       input logic is_last, output logic done,
                                       output logic [0:4][31:0] dig);
      int pos, nxt, nb, i;
      logic [31:0] w;
      logic [63:0] bits;
      pos = int'({msg_bytes[5:2], 2'b00});
      done = 1'b0;
      dig = '0;
      if (!is_last) begin
         // valid byte count is ignored on body words
         blk_w[4'(pos / 4)] = data;
         msg_bytes += 61'd4;
         if (pos == 60)
            sha1_compress();
         return;
      end
      nb = (nb_in > 3'd4) ? 4 : int'(nb_in);   // counts above four saturate
      w = (nb == 0) ? 32'h0 : (data & (32'hFFFF_FFFF << (8 * (4 - nb))));
      if (nb < 4)
         w |= 32'h80 << (8 * (3 - nb));
      blk_w[4'(pos / 4)] = w;
      msg_bytes += 61'(nb);
      nxt = pos + 4;
      if (nb == 4) begin
         // full last word: pad marker goes into the following word
         if (nxt == 64) begin
            sha1_compress();
            nxt = 0;
         end
         blk_w[4'(nxt / 4)] = 32'h8000_0000;
         nxt += 4;
      end
      if (nxt > 56) begin
         // no room for the length, spill into an extra block
         for (i = nxt / 4; i < 16; i++)
            blk_w[4'(i)] = '0;
         sha1_compress();
         nxt = 0;
      end
      for (i = nxt / 4; i < 14; i++)
         blk_w[4'(i)] = '0;
      bits = {msg_bytes, 3'b000};
      blk_w[14] = bits[63:32];
      blk_w[15] = bits[31:0];
      sha1_compress();
      for (i = 0; i < 5; i++)
         dig[3'(i)] = hash_h[3'(i)];
      done = 1'b1;
      hash_restart();
   endfunction

   function automatic void report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s", what);
   endfunction

   function automatic logic [31:0] rand_data();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // offer one word, wait for the handshake, then log the expected digest words
   task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic is_last,
                            input logic use_typed, input logic [0:4][31:0] typed);
      logic done;
      logic [0:4][31:0] dig;
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, nb, data};
      req_tlast  <= is_last;
      do
         @(posedge clock);
      while (!req_tready);
      absorb_word(data, nb, is_last, done, dig);
      if (done) begin
         for (int i = 0; i < 5; i++)
            digest_q.push_back('{use_typed ? typed[3'(i)] : dig[3'(i)], 3'(i), i == 4});
      end
      words_sent++;
   endtask

   // random message: mostly short, some right around block boundaries, a few long
   task automatic send_message();
      int n_body, r;
      logic [2:0] nb_last;
      r = $urandom_range(0, 9);
      if (r < 7)
         n_body = $urandom_range(0, 18);
      else if (r < 9)
         n_body = $urandom_range(13, 16) + 16 * $urandom_range(0, 1);
      else
         n_body = $urandom_range(20, 70);
      repeat (n_body)
         send_word(rand_data(), 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
      r = $urandom_range(0, 9);
      nb_last = (r < 8) ? 3'(r % 5) : 3'($urandom_range(5, 7));
      send_word(rand_data(), nb_last, 1'b1, 1'b0, '0);
   endtask

   // result side: random stalls, plus a long hold-off counted down here when requested
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
   end

   // compare each accepted digest word against the oldest expectation
   always @(posedge clock) begin : check_digest
      digest_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            report_mismatch($sformatf("unexpected digest word %h index %0d last %b",
                                      rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast));
         end else begin
            want = digest_q.pop_front();
            if (rsp_tdata[31:0] !== want.word || rsp_tdata[34:32] !== want.idx ||
                rsp_tlast !== want.fin)
               report_mismatch($sformatf("expected %h/%0d/%b, got %h/%0d/%b",
                                         want.word, want.idx, want.fin,
                                         rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast));
         end
      end
   end

   stim_row_type dir_rows [DIR_ROWS];

   initial begin
      int ph;
      dir_rows = '{
         // empty message, straight after reset
         '{32'h0000_0000, 3'd0, 1'b1, 1'b1, DIGEST_EMPTY},
         // three-byte message
         '{32'h6162_6300, 3'd3, 1'b1, 1'b1, DIGEST_ABC},
         // no valid bytes: data is dropped, same as empty
         '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, DIGEST_EMPTY},
         '{32'h6100_0000, 3'd1, 1'b1, 1'b1, DIGEST_A},
         // oversized byte counts on the last word saturate to four
         '{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, 160'h0},
         '{32'h1234_5678, 3'd5, 1'b1, 1'b0, 160'h0},
         '{32'h8000_0001, 3'd6, 1'b1, 1'b0, 160'h0},
         '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 160'h0},
         // fifteen-word message: byte counts on body words ignored, length spills
         '{32'h0000_0000, 3'd0, 1'b0, 1'b0, 160'h0},
         '{32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0, 160'h0},
         '{32'h0123_4567, 3'd4, 1'b0, 1'b0, 160'h0},
         '{32'h89AB_CDEF, 3'd1, 1'b0, 1'b0, 160'h0},
         '{32'h5555_5555, 3'd2, 1'b0, 1'b0, 160'h0},
         '{32'hAAAA_AAAA, 3'd3, 1'b0, 1'b0, 160'h0},
         '{32'h8000_0000, 3'd5, 1'b0, 1'b0, 160'h0},
         '{32'h0000_0001, 3'd6, 1'b0, 1'b0, 160'h0},
         '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 160'h0},
         '{32'h0000_0000, 3'd7, 1'b0, 1'b0, 160'h0},
         '{32'hDEAD_BEEF, 3'd4, 1'b0, 1'b0, 160'h0},
         '{32'hCAFE_F00D, 3'd2, 1'b0, 1'b0, 160'h0},
         '{32'h7FFF_FFFF, 3'd1, 1'b0, 1'b0, 160'h0},
         '{32'hFFFF_FFFE, 3'd3, 1'b0, 1'b0, 160'h0},
         '{32'h6162_6364, 3'd2, 1'b1, 1'b0, 160'h0}
      };
      hash_restart();
      for (int i = 0; i < 16; i++)
         blk_w[4'(i)] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling on either side
      foreach (dir_rows[i])
         send_word(dir_rows[i].data, dir_rows[i].nb, dir_rows[i].fin,
                   dir_rows[i].typed, dir_rows[i].digest);

      // pause until every digest word is back
      req_tvalid <= 1'b0;
      while (digest_q.size() != 0)
         @(posedge clock);

      // back-pressure: result side holds off while a few messages queue up
      rsp_hold_cycles = 1500;
      repeat (3)
         send_message();

      // random phases: none, sender idle, receiver stall, both
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         while (words_sent < DIR_ROWS + (ph + 1) * RAND_PER_PHASE)
            send_message();
      end

      // drain, then allow for a stray late word
      req_tvalid <= 1'b0;
      while (digest_q.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);

      if (digest_q.size() != 0)
         report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));
      if (mismatch_count == 0) begin
         $display("** sha1_hash_engine: PASSED **");
      end else begin
         $display("** sha1_hash_engine: FAILED **");
      end
      $finish;
   end

   // run limit, several times the slowest correct run
   initial begin
      #10_000_000;
      $display("timeout, %0d digest words outstanding", digest_q.size());
      $display("** sha1_hash_engine: FAILED **");
      $finish;
   end

endmodule
